// ----- hw/rtl/uscar_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uscar_pkg: shared types and constants
// Opcodes, reply kinds and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package uscar_pkg;

   localparam int MaxInit            = 128;
   localparam int RxBufferBytes      = 2048;
   localparam logic [15:0] ProvisionalSession = 16'd4660;
   localparam logic [15:0] HdrBytes   = 16'd12;
   localparam logic [15:0] DefaultTimeout = 16'd5000;
   localparam int MapBits  = MaxInit;
   localparam int MapIdxW  = $clog2(MapBits);

   localparam logic [2:0] OP_HEADER  = 3'd0;
   localparam logic [2:0] OP_SERVICE = 3'd1;
   localparam logic [2:0] OP_TICK    = 3'd2;
   localparam logic [2:0] OP_SWITCH  = 3'd3;
   localparam logic [2:0] OP_CONNECT = 3'd4;

   localparam logic [2:0] KIND_HELLO     = 3'd0;
   localparam logic [2:0] KIND_HELLO_ACK = 3'd1;
   localparam logic [2:0] KIND_ACK       = 3'd2;
   localparam logic [2:0] KIND_EMPTY     = 3'd3;
   localparam logic [2:0] KIND_RESEND    = 3'd4;
   localparam logic [2:0] KIND_PREVIEW   = 3'd5;
   localparam logic [2:0] KIND_PROGRAM   = 3'd6;
   localparam logic [2:0] KIND_AUTO      = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] datagram_size;
      logic [15:0] header_session;
      logic        flag_hello;
      logic        flag_ack_request;
      logic        flag_resend;
      logic        flag_request_next;
      logic [15:0] header_packet_id;
      logic [15:0] header_length;
      logic [15:0] requested_next_id;
      logic [7:0]  source_input;
      logic        use_auto;
   } req_type;

   typedef struct packed {
      logic [2:0]  send_kind;
      logic [15:0] session_id;
      logic [15:0] packet_number;
      logic [7:0]  command_source;
      logic        connected;
      logic        last;
   } rsp_type;

   // Controller -> datapath
   typedef struct packed {
      logic load;        // latch request
      logic exec;        // perform the main update for the latched request
      logic scan_start;  // set scan index to 1
      logic scan_step;   // advance scan index
      logic scan_hit;    // queue resend request for current index minus one
      logic scan_done;   // finish scan without a hit
      logic watchdog;    // evaluate watchdog
      logic pop;         // one result taken
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic       is_service;
      logic       scan_needed;
      logic       scan_end;
      logic       scan_bit;
      logic [1:0] pending;
   } sts_type;

endpackage
`default_nettype wire

// ----- hw/rtl/uscar_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uscar_req_if / uscar_rsp_if: valid/ready channels
// Carry one request or one result transaction per handshake.
// ----------------------------------------------------------------------------
interface uscar_req_if;
   logic valid;
   logic ready;
   uscar_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface uscar_rsp_if;
   logic valid;
   logic ready;
   uscar_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/uscar_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uscar_datapath: session state and reply queue
// Holds session registers, the missing map and up to two pending results.
// ----------------------------------------------------------------------------
module uscar_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire uscar_pkg::req_type req_in,
   input  wire logic csr_write,
   input  wire logic [15:0] csr_wdata,
   input  wire uscar_pkg::cmd_type cmd,
   output uscar_pkg::sts_type sts,
   output uscar_pkg::rsp_type rsp_head
);
   localparam int IdxW = uscar_pkg::MapIdxW + 1;

   uscar_pkg::req_type req_ff;
   logic [15:0] timeout_ff, session_ff, counter_ff, remote_ff, end_ff, idle_ff;
   logic [uscar_pkg::MapBits-1:0] map_ff;
   logic link_ff, dump_ff, init_ff, wait_ff;
   logic [IdxW-1:0] idx_ff;
   uscar_pkg::rsp_type q0_ff, q1_ff;
   logic [1:0] cnt_ff;

   logic [15:0] nread, idx_ext;
   logic hdr_ok, len_ok, dump_now, dump_next;
   logic [15:0] sess_next, rem_next, c1, c2;
   logic link_next;
   logic ack, emp;

   always_comb begin
      nread = (req_ff.datagram_size < 16'(uscar_pkg::RxBufferBytes)) ?
              req_ff.datagram_size : 16'(uscar_pkg::RxBufferBytes);
      hdr_ok = nread >= uscar_pkg::HdrBytes;
      len_ok = req_ff.datagram_size == req_ff.header_length;
      sess_next = req_ff.header_session;
      rem_next = req_ff.header_packet_id;
      dump_now = !dump_ff && nread == uscar_pkg::HdrBytes && rem_next > 16'd1;
      dump_next = dump_ff || dump_now;
      link_next = link_ff || req_ff.flag_hello;
      ack = dump_next && req_ff.flag_ack_request &&
            (init_ff || !req_ff.flag_resend);
      emp = !ack && dump_next && req_ff.flag_request_next && init_ff;
      c1 = counter_ff + 16'd1;
      c2 = counter_ff + 16'd2;
      idx_ext = 16'(idx_ff);
   end

   always_comb begin
      sts.is_service = req_ff.op == uscar_pkg::OP_SERVICE;
      sts.scan_needed = !init_ff && dump_ff && !wait_ff;
      sts.scan_end = !(idx_ext < end_ff && idx_ext < 16'(uscar_pkg::MaxInit));
      sts.scan_bit = map_ff[idx_ff[uscar_pkg::MapIdxW-1:0]];
      sts.pending = cnt_ff;
      rsp_head = q0_ff;
   end

   function automatic uscar_pkg::rsp_type mk(logic [2:0] k, logic [15:0] s,
                                             logic [15:0] n, logic [7:0] src,
                                             logic con, logic lst);
      uscar_pkg::rsp_type r;
      r.send_kind = k; r.session_id = s; r.packet_number = n;
      r.command_source = src; r.connected = con; r.last = lst;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= uscar_pkg::DefaultTimeout;
         session_ff <= uscar_pkg::ProvisionalSession;
         counter_ff <= '0;
         remote_ff <= '0;
         end_ff <= 16'(uscar_pkg::MaxInit);
         idle_ff <= '0;
         map_ff <= '1;
         link_ff <= 1'b0; dump_ff <= 1'b0; init_ff <= 1'b0; wait_ff <= 1'b0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         if (csr_write) timeout_ff <= csr_wdata;
         if (cmd.load) req_ff <= req_in;
         if (cmd.pop) begin
            q0_ff <= q1_ff;
            cnt_ff <= cnt_ff - 2'd1;
         end
         if (cmd.scan_start) idx_ff <= IdxW'(1);
         if (cmd.scan_step) idx_ff <= idx_ff + IdxW'(1);
         if (cmd.scan_hit) begin
            wait_ff <= 1'b1;
            q0_ff <= mk(uscar_pkg::KIND_RESEND, session_ff, idx_ext - 16'd1, 8'd0,
                        link_ff, 1'b0);
            cnt_ff <= 2'd1;
         end
         if (cmd.scan_done) init_ff <= 1'b1;
         if (cmd.watchdog) begin
            if (idle_ff >= timeout_ff) begin
               counter_ff <= '0;
               link_ff <= 1'b0; dump_ff <= 1'b0; init_ff <= 1'b0; wait_ff <= 1'b0;
               session_ff <= uscar_pkg::ProvisionalSession;
               end_ff <= 16'(uscar_pkg::MaxInit);
               idle_ff <= '0;
               map_ff <= '1;
               if (cnt_ff == 2'd1) begin
                  q0_ff.connected <= 1'b0;
                  q1_ff <= mk(uscar_pkg::KIND_HELLO, uscar_pkg::ProvisionalSession,
                              16'd0, 8'd0, 1'b0, 1'b1);
                  cnt_ff <= 2'd2;
               end else begin
                  q0_ff <= mk(uscar_pkg::KIND_HELLO, uscar_pkg::ProvisionalSession,
                              16'd0, 8'd0, 1'b0, 1'b1);
                  cnt_ff <= 2'd1;
               end
            end else if (cnt_ff == 2'd1) begin
               q0_ff.last <= 1'b1;
            end
         end
         if (cmd.exec) begin
            unique case (req_ff.op)
               uscar_pkg::OP_HEADER: begin
                  if (hdr_ok) begin
                     session_ff <= sess_next;
                     remote_ff <= rem_next;
                     if (rem_next < 16'(uscar_pkg::MaxInit))
                        map_ff[rem_next[uscar_pkg::MapIdxW-1:0]] <= 1'b0;
                     if (len_ok) begin
                        idle_ff <= '0;
                        wait_ff <= 1'b0;
                        link_ff <= link_next;
                        if (dump_now) begin
                           dump_ff <= 1'b1;
                           end_ff <= rem_next;
                        end
                        if (req_ff.flag_hello) begin
                           q0_ff <= mk(uscar_pkg::KIND_HELLO_ACK, sess_next, 16'd0,
                                       8'd0, link_next, !(ack || emp));
                           q1_ff <= mk(ack ? uscar_pkg::KIND_ACK : uscar_pkg::KIND_EMPTY,
                                       sess_next, ack ? rem_next : req_ff.requested_next_id,
                                       8'd0, link_next, 1'b1);
                           cnt_ff <= (ack || emp) ? 2'd2 : 2'd1;
                        end else if (ack || emp) begin
                           q0_ff <= mk(ack ? uscar_pkg::KIND_ACK : uscar_pkg::KIND_EMPTY,
                                       sess_next, ack ? rem_next : req_ff.requested_next_id,
                                       8'd0, link_next, 1'b1);
                           cnt_ff <= 2'd1;
                        end
                     end
                  end
               end
               uscar_pkg::OP_TICK: begin
                  if (idle_ff != 16'hFFFF) idle_ff <= idle_ff + 16'd1;
               end
               uscar_pkg::OP_SWITCH: begin
                  if (req_ff.source_input != 8'd0 && link_ff) begin
                     if (req_ff.use_auto) begin
                        counter_ff <= c2;
                        q0_ff <= mk(uscar_pkg::KIND_PREVIEW, session_ff, c1,
                                    req_ff.source_input, link_ff, 1'b0);
                        q1_ff <= mk(uscar_pkg::KIND_AUTO, session_ff, c2,
                                    req_ff.source_input, link_ff, 1'b1);
                        cnt_ff <= 2'd2;
                     end else begin
                        counter_ff <= c1;
                        q0_ff <= mk(uscar_pkg::KIND_PROGRAM, session_ff, c1,
                                    req_ff.source_input, link_ff, 1'b1);
                        cnt_ff <= 2'd1;
                     end
                  end
               end
               uscar_pkg::OP_CONNECT: begin
                  counter_ff <= '0;
                  link_ff <= 1'b0; dump_ff <= 1'b0; init_ff <= 1'b0; wait_ff <= 1'b0;
                  session_ff <= uscar_pkg::ProvisionalSession;
                  end_ff <= 16'(uscar_pkg::MaxInit);
                  idle_ff <= '0;
                  map_ff <= '1;
                  q0_ff <= mk(uscar_pkg::KIND_HELLO, uscar_pkg::ProvisionalSession,
                              16'd0, 8'd0, 1'b0, 1'b1);
                  cnt_ff <= 2'd1;
               end
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/uscar_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uscar_ctrl: sequencing state machine
// Accept, execute or scan, run the watchdog, drain results.
// ----------------------------------------------------------------------------
module uscar_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire uscar_pkg::sts_type sts,
   output uscar_pkg::cmd_type cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_WDOG = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.is_service) begin
               if (sts.scan_needed) begin
                  cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end else state_in = S_WDOG;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_OUT;
            end
         end
         S_SCAN: begin
            if (sts.scan_end) begin
               cmd.scan_done = 1'b1;
               state_in = S_WDOG;
            end else if (sts.scan_bit) begin
               cmd.scan_hit = 1'b1;
               state_in = S_WDOG;
            end else cmd.scan_step = 1'b1;
         end
         S_WDOG: begin
            cmd.watchdog = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (sts.pending == 2'd0) state_in = S_IDLE;
            else begin
               rsp_valid = 1'b1;
               if (rsp_ready) begin
                  cmd.pop = 1'b1;
                  if (sts.pending == 2'd1) state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ----- hw/rtl/udp_session_client_ack_resend_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_session_client_ack_resend_top: reliable UDP session client
// Sequence: a request is accepted in IDLE, executed in EXEC and its results
//   are offered from OUT; a service pass runs EXEC, the map scan (SCAN, one
//   bit checked per step, bits 1 to 127 at most) and WDOG before OUT.
// Throughput: one transaction at a time; a new request is taken only once
//   OUT has drained every result.
// Reset: synchronous, active high; restores provisional session, full map.
// ----------------------------------------------------------------------------
module udp_session_client_ack_resend_top (
   input  wire logic clock,
   input  wire logic reset,
   uscar_req_if.sink req,
   uscar_rsp_if.source rsp,
   input  wire logic csr_write,
   input  wire logic [15:0] csr_wdata
);
   uscar_pkg::cmd_type cmd;
   uscar_pkg::sts_type sts;

   // Sequence each transaction: load, execute or scan, watchdog, drain.
   uscar_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts(sts), .cmd(cmd)
   );

   // Hold session state and queue replies.
   uscar_datapath u_dp (
      .clock(clock), .reset(reset),
      .req_in(req.data), .csr_write(csr_write), .csr_wdata(csr_wdata),
      .cmd(cmd), .sts(sts), .rsp_head(rsp.data)
   );
endmodule
`default_nettype wire
